// ----- rtl/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, widths and codes of the contiguous frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // Pool capacity and derived widths
    localparam int MAX_FRAMES = 4096;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;

    // Field widths
    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 13;
    localparam int POOL_W   = 13;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FS_W     = 2;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 1'b1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ALLOC_FAIL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_REL_REFUSED = 2'd2;

    // Per-frame state codes
    localparam logic [FS_W-1:0] FS_FREE  = 2'd0;
    localparam logic [FS_W-1:0] FS_HEAD  = 2'd1;
    localparam logic [FS_W-1:0] FS_USED  = 2'd2;
    localparam logic [FS_W-1:0] FS_INACC = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_SCAN,
        ST_A_WRITE,
        ST_R_HEAD,
        ST_R_RUN,
        ST_MARK,
        ST_RESP
    } t_state;

    // Pool configuration seen by the sequencer
    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [CNT_W-1:0]   pool_n;
    } t_cfg;

    // Finished transaction handed to the output register
    typedef struct packed {
        logic                valid;
        logic [FRAME_W-1:0]  first_frame;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/cfa_ram.sv -----
// ----------------------------------------------------------------------------
// cfa_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfa_ctrl
// Command sequencer: clears the frame-state RAM after reset, then runs the
// first-fit scan, the run marking, the release walk and the range marking.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [cfa_pkg::CMD_W-1:0]    i_command,
    input  wire logic [cfa_pkg::FRAME_W-1:0]  i_frame,
    input  wire logic [cfa_pkg::COUNT_W-1:0]  i_count,
    input  wire cfa_pkg::t_cfg                i_cfg,
    input  wire logic                         i_out_free,
    output cfa_pkg::t_res                     o_res
);

    localparam int IW = cfa_pkg::IDX_W;
    localparam int CW = cfa_pkg::CNT_W;

    cfa_pkg::t_state r_state, n_state;

    logic [CW-1:0]                   r_ptr, n_ptr;
    logic                            r_dv, n_dv;
    logic [CW-1:0]                   r_len, n_len;
    logic [CW-1:0]                   r_count, n_count;
    logic [IW-1:0]                   r_start, n_start;
    logic [IW-1:0]                   r_wptr, n_wptr;
    logic [CW-1:0]                   r_rem, n_rem;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [cfa_pkg::FRAME_W-1:0]     r_moff, n_moff;
    logic [cfa_pkg::COUNT_W-1:0]     r_mcnt, n_mcnt;
    logic [cfa_pkg::FRAME_W-1:0]     r_first, n_first;
    logic [cfa_pkg::STATUS_W-1:0]    r_status, n_status;

    logic                            ram_we, ram_re;
    logic [IW-1:0]                   ram_waddr, ram_raddr;
    logic [cfa_pkg::FS_W-1:0]        ram_wdata, ram_rdata;

    logic                            accept;
    logic [cfa_pkg::FRAME_W-1:0]     in_off;
    logic                            rel_bad, alloc_bad;
    logic [CW-1:0]                   data_idx;
    logic                            scan_hit, scan_end, scan_issue;
    logic [IW-1:0]                   hit_start;
    logic [CW-1:0]                   rel_next;
    logic                            rel_more;
    logic                            wr_last, mark_last, mark_own, clr_last;

    // Frame-state store
    cfa_ram #(
        .DEPTH (cfa_pkg::MAX_FRAMES),
        .WIDTH (cfa_pkg::FS_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared decode
    assign accept     = i_in_valid && (r_state == cfa_pkg::ST_IDLE);
    assign o_in_stall = (r_state != cfa_pkg::ST_IDLE);
    assign in_off     = i_frame - i_cfg.base;
    assign rel_bad    = 32'(in_off) >= 32'(i_cfg.pool_n);
    assign alloc_bad  = (i_count == '0) || (32'(i_count) > 32'(i_cfg.pool_n));
    assign data_idx   = r_ptr - CW'(1);
    assign scan_hit   = r_dv && (ram_rdata == cfa_pkg::FS_FREE)
                        && ((r_len + CW'(1)) == r_count);
    assign scan_end   = !r_dv && (r_ptr == i_cfg.pool_n);
    assign scan_issue = (r_ptr < i_cfg.pool_n) && !scan_hit;
    assign hit_start  = (r_len == '0) ? data_idx[IW-1:0] : r_start;
    assign rel_next   = {1'b0, r_idx} + CW'(1);
    assign rel_more   = rel_next < i_cfg.pool_n;
    assign wr_last    = (r_rem == CW'(1));
    assign mark_last  = (r_mcnt == cfa_pkg::COUNT_W'(1));
    assign mark_own   = 32'(r_moff) < 32'(i_cfg.pool_n);
    assign clr_last   = (r_ptr == CW'(cfa_pkg::MAX_FRAMES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfa_pkg::ST_CLEAR: begin
                if (clr_last) n_state = cfa_pkg::ST_IDLE;
            end
            cfa_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_command)
                        cfa_pkg::CMD_ALLOC: begin
                            n_state = alloc_bad ? cfa_pkg::ST_RESP : cfa_pkg::ST_A_SCAN;
                        end
                        cfa_pkg::CMD_RELEASE: begin
                            n_state = rel_bad ? cfa_pkg::ST_RESP : cfa_pkg::ST_R_HEAD;
                        end
                        cfa_pkg::CMD_MARK: begin
                            n_state = (i_count == '0) ? cfa_pkg::ST_RESP : cfa_pkg::ST_MARK;
                        end
                        default: n_state = cfa_pkg::ST_RESP;
                    endcase
                end
            end
            cfa_pkg::ST_A_SCAN: begin
                if (scan_hit)      n_state = cfa_pkg::ST_A_WRITE;
                else if (scan_end) n_state = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_A_WRITE: begin
                if (wr_last) n_state = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_R_HEAD: begin
                if (ram_rdata == cfa_pkg::FS_HEAD && rel_more) n_state = cfa_pkg::ST_R_RUN;
                else                                           n_state = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_R_RUN: begin
                if (!(ram_rdata == cfa_pkg::FS_USED && rel_more)) n_state = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_MARK: begin
                if (mark_last) n_state = cfa_pkg::ST_RESP;
            end
            cfa_pkg::ST_RESP: begin
                if (i_out_free) n_state = cfa_pkg::ST_IDLE;
            end
            default: n_state = cfa_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_ptr     = r_ptr;
        n_dv      = 1'b0;
        n_len     = r_len;
        n_count   = r_count;
        n_start   = r_start;
        n_wptr    = r_wptr;
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_moff    = r_moff;
        n_mcnt    = r_mcnt;
        n_first   = r_first;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_wptr;
        ram_wdata = cfa_pkg::FS_FREE;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[IW-1:0];
        o_res     = '0;

        case (r_state)
            // Sweep the store to free after reset
            cfa_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IW-1:0];
                ram_wdata = cfa_pkg::FS_FREE;
                n_ptr     = clr_last ? '0 : r_ptr + CW'(1);
            end
            // Latch the transaction and set up its walk
            cfa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_first  = '0;
                    n_status = cfa_pkg::STS_OK;
                    case (i_command)
                        cfa_pkg::CMD_ALLOC: begin
                            n_ptr   = '0;
                            n_len   = '0;
                            n_count = CW'(i_count);
                            if (alloc_bad) n_status = cfa_pkg::STS_ALLOC_FAIL;
                        end
                        cfa_pkg::CMD_RELEASE: begin
                            if (rel_bad) begin
                                n_status = cfa_pkg::STS_REL_REFUSED;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = in_off[IW-1:0];
                                n_idx     = in_off[IW-1:0];
                            end
                        end
                        cfa_pkg::CMD_MARK: begin
                            n_moff = in_off;
                            n_mcnt = i_count;
                        end
                        default: ;
                    endcase
                end
            end
            // First-fit scan: issue one read and check one returned state per cycle
            cfa_pkg::ST_A_SCAN: begin
                if (r_dv) begin
                    if (ram_rdata == cfa_pkg::FS_FREE) begin
                        if (r_len == '0) n_start = data_idx[IW-1:0];
                        n_len = r_len + CW'(1);
                    end else begin
                        n_len = '0;
                    end
                end
                if (scan_hit) begin
                    n_start = hit_start;
                    n_wptr  = hit_start;
                    n_rem   = r_count;
                    n_first = i_cfg.base + cfa_pkg::FRAME_W'(hit_start);
                end else if (scan_end) begin
                    n_status = cfa_pkg::STS_ALLOC_FAIL;
                end
                if (scan_issue) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr[IW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_dv      = 1'b1;
                end
            end
            // Mark the found run: head first, then used frames
            cfa_pkg::ST_A_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_wptr;
                ram_wdata = (r_wptr == r_start) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
                n_wptr    = r_wptr + IW'(1);
                n_rem     = r_rem - CW'(1);
            end
            // Check the head, free it and fetch the next frame
            cfa_pkg::ST_R_HEAD: begin
                if (ram_rdata == cfa_pkg::FS_HEAD) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = cfa_pkg::FS_FREE;
                    if (rel_more) begin
                        ram_re    = 1'b1;
                        ram_raddr = rel_next[IW-1:0];
                        n_idx     = rel_next[IW-1:0];
                    end
                end else begin
                    n_status = cfa_pkg::STS_REL_REFUSED;
                end
            end
            // Free used frames until a non-used frame or the pool end
            cfa_pkg::ST_R_RUN: begin
                if (ram_rdata == cfa_pkg::FS_USED) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = cfa_pkg::FS_FREE;
                    if (rel_more) begin
                        ram_re    = 1'b1;
                        ram_raddr = rel_next[IW-1:0];
                        n_idx     = rel_next[IW-1:0];
                    end
                end
            end
            // Mark owned frames of the range, one frame per cycle
            cfa_pkg::ST_MARK: begin
                ram_we    = mark_own;
                ram_waddr = r_moff[IW-1:0];
                ram_wdata = cfa_pkg::FS_INACC;
                n_moff    = r_moff + cfa_pkg::FRAME_W'(1);
                n_mcnt    = r_mcnt - cfa_pkg::COUNT_W'(1);
            end
            // Hand the result over once the output register has room
            cfa_pkg::ST_RESP: begin
                o_res.valid       = i_out_free;
                o_res.first_frame = r_first;
                o_res.status      = r_status;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::ST_CLEAR;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_dv    <= n_dv;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_count  <= n_count;
        r_start  <= n_start;
        r_wptr   <= n_wptr;
        r_rem    <= n_rem;
        r_idx    <= n_idx;
        r_moff   <= n_moff;
        r_mcnt   <= n_mcnt;
        r_first  <= n_first;
        r_status <= n_status;
    end

`ifndef SYNTHESIS
    // A read and a write never target the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && ram_waddr == ram_raddr))
        else $error("frame-state read and write collide");

    // An accepted transaction always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != cfa_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accept");

    // Run marking stays inside the pool
    a_write_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfa_pkg::ST_A_WRITE) |-> (CW'(r_wptr) < i_cfg.pool_n))
        else $error("run marking beyond pool end");

    // A failed or refused result carries frame zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != cfa_pkg::STS_OK) |-> (o_res.first_frame == '0))
        else $error("failed result with nonzero frame");
`endif

endmodule

`default_nettype wire

// ----- rtl/contiguous_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_top
// First-fit allocator of contiguous frame runs over one pool, with config
// registers and a registered output stage.
// ----------------------------------------------------------------------------
// Allocate scans the pool one frame per cycle, then writes the found run one
//   frame per cycle; release walks the run from its head; mark walks the range.
//   One transaction in flight, set by the single RAM walk.
// Reset: synchronous; a clearing pass writes all MAX_FRAMES (4096) entries to
//   free, one per cycle, with the input stalled. Config writes are taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_frame_allocator_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cfa_pkg::FRAME_W-1:0]     i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [cfa_pkg::CMD_W-1:0]       i_command,
    input  wire logic [cfa_pkg::FRAME_W-1:0]     i_frame,
    input  wire logic [cfa_pkg::COUNT_W-1:0]     i_count,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [cfa_pkg::FRAME_W-1:0]          o_first_frame,
    output logic [cfa_pkg::STATUS_W-1:0]         o_status
);

    logic [cfa_pkg::FRAME_W-1:0]  r_base;
    logic [cfa_pkg::POOL_W-1:0]   r_pool;
    logic                         r_ovalid;
    logic [cfa_pkg::FRAME_W-1:0]  r_ofirst;
    logic [cfa_pkg::STATUS_W-1:0] r_ostatus;

    cfa_pkg::t_cfg cfg;
    cfa_pkg::t_res res;
    logic          out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pool <= cfa_pkg::POOL_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfa_pkg::CFG_BASE_FRAME:  r_base <= i_cfg_wdata;
                cfa_pkg::CFG_POOL_FRAMES: r_pool <= i_cfg_wdata[cfa_pkg::POOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the pool size to the store depth
    assign cfg.base   = r_base;
    assign cfg.pool_n = (32'(r_pool) > 32'(cfa_pkg::MAX_FRAMES))
                        ? cfa_pkg::CNT_W'(cfa_pkg::MAX_FRAMES)
                        : cfa_pkg::CNT_W'(r_pool);

    assign out_free = !r_ovalid || !i_out_stall;

    cfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_frame    (i_frame),
        .i_count    (i_count),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_res      (res)
    );

    // Output register: load a finished transaction, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_ofirst  <= res.first_frame;
            r_ostatus <= res.status;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_first_frame = r_ofirst;
    assign o_status      = r_ostatus;

endmodule

`default_nettype wire
